// ----- hw/rtl/fpl_pkg.sv -----
`default_nettype none
package fpl_pkg;

  localparam int TsW     = 63;
  localparam int SyncW   = 3;
  localparam int TgtW    = 24;
  localparam int RefW    = 24;
  localparam int GranW   = 20;
  localparam int CfgW    = 24;
  localparam int CfgIdxW = 2;
  localparam int SleepW  = 40;
  localparam int CoarseW = 39;
  localparam int ThW     = 32;
  localparam int CntW    = 32;

  localparam logic [GranW-1:0] GRAN_RESET = GranW'(10000);

  localparam logic [CfgIdxW-1:0] CFG_TARGET  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_REFRESH = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_GRAN    = 2'd2;

  typedef enum logic [2:0] {
    ACT_BYPASS = 3'd0,
    ACT_SLOW   = 3'd1,
    ACT_DONE   = 3'd2,
    ACT_SLEEP  = 3'd3,
    ACT_STRAY  = 3'd4
  } action_e;

  typedef struct packed {
    logic [TgtW-1:0]  target;
    logic [RefW-1:0]  refresh;
    logic [GranW-1:0] gran;
  } cfg_t;

  typedef struct packed {
    logic             req_type;
    logic [TsW-1:0]   timestamp;
    logic [SyncW-1:0] sync_interval;
  } item_t;

  typedef struct packed {
    action_e                  action;
    logic signed [SleepW-1:0] sleep_total;
    logic [CoarseW-1:0]       coarse_sleep;
    logic [ThW-1:0]           threshold;
  } result_t;

endpackage
`default_nettype wire

// ----- hw/rtl/fpl_reg_stage.sv -----
`default_nettype none
module fpl_reg_stage #(
  parameter type T = logic
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic s_valid_i,
  output logic      s_ready_o,
  input  wire T     s_data_i,
  output logic      m_valid_o,
  input  wire logic m_ready_i,
  output T          m_data_o
);

  logic valid_q;
  T     data_q;

  // load when empty or when the held transaction leaves this cycle
  assign s_ready_o = !valid_q || m_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_ready_o) begin
      valid_q <= s_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_ready_o && s_valid_i) begin
      data_q <= s_data_i;
    end
  end

  assign m_valid_o = valid_q;
  assign m_data_o  = data_q;

endmodule
`default_nettype wire

// ----- hw/rtl/fpl_core.sv -----
`default_nettype none
module fpl_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire fpl_pkg::cfg_t    cfg_i,
  input  wire logic             fire_i,
  input  wire fpl_pkg::item_t   item_i,
  output fpl_pkg::result_t      result_o
);
  import fpl_pkg::*;

  localparam logic signed [48:0] FT_MAX  = 49'sd1 <<< 47;
  localparam logic signed [48:0] FT_MIN  = -FT_MAX;
  localparam logic signed [51:0] S40_MAX = 52'sd549755813887;
  localparam logic signed [51:0] S40_MIN = -52'sd549755813888;

  function automatic logic signed [SleepW-1:0] sat_s40(input logic signed [51:0] v);
    if (v > S40_MAX) begin
      return S40_MAX[SleepW-1:0];
    end else if (v < S40_MIN) begin
      return S40_MIN[SleepW-1:0];
    end
    return v[SleepW-1:0];
  endfunction

  function automatic logic [ThW-1:0] sat_th(input logic [GranW-1:0] gran,
                                            input logic [CntW-1:0] bump);
    logic [ThW:0] sum;
    sum = (ThW+1)'({gran, 1'b0}) + (ThW+1)'(bump);
    return sum[ThW] ? {ThW{1'b1}} : sum[ThW-1:0];
  endfunction

  logic [TsW-1:0]           last_frame_time_q, last_frame_time_d;
  logic signed [SleepW-1:0] deviation_q, deviation_d;
  logic [CntW-1:0]          late_count_q, late_count_d;
  logic [CntW-1:0]          ontime_count_q, ontime_count_d;
  logic [CntW-1:0]          threshold_bump_q, threshold_bump_d;
  logic                     wake_pending_q, wake_pending_d;
  logic signed [SleepW-1:0] pending_sleep_q, pending_sleep_d;

  logic signed [64:0]       diff;
  logic signed [48:0]       ft;
  logic [33:0]              vs_lhs, vs_rhs;
  logic                     bypass;
  logic signed [56:0]       ft100, slow_lim;
  logic                     slow;
  logic signed [SleepW-1:0] sleep;
  logic [ThW-1:0]           th_cur;
  logic signed [40:0]       coarse_diff;
  logic signed [51:0]       dev_sum;
  logic [TgtW-5:0]          dev_cap;
  logic signed [SleepW-1:0] dev_upd;
  logic [TgtW:0]            late_lim;
  logic                     late;
  logic [CntW-1:0]          late_n, ontime_n;
  logic                     bump_hit;
  logic [CntW:0]            bump_sum;

  always_comb begin
    diff = $signed({2'b00, item_i.timestamp}) - $signed({2'b00, last_frame_time_q});
    if (diff > 65'(FT_MAX)) begin
      ft = FT_MAX;
    end else if (diff < 65'(FT_MIN)) begin
      ft = FT_MIN;
    end else begin
      ft = diff[48:0];
    end
  end

  assign vs_lhs = 34'(cfg_i.refresh) * 34'(item_i.sync_interval) * 34'd100;
  assign vs_rhs = 34'(cfg_i.target) * 34'd97;
  assign bypass = (cfg_i.target == '0) || (vs_lhs > vs_rhs);

  assign ft100    = 57'(ft) * 57'sd100;
  assign slow_lim = 57'($signed({1'b0, cfg_i.target})) * 57'sd103
                  - 57'(deviation_q) * 57'sd100;
  assign slow     = ft100 > slow_lim;

  assign sleep = sat_s40(52'($signed({1'b0, cfg_i.target})) - 52'(deviation_q) - 52'(ft));

  assign th_cur      = sat_th(cfg_i.gran, threshold_bump_q);
  assign coarse_diff = 41'(sleep) - $signed({9'd0, th_cur});

  // accumulate the deviation, capped at target/16
  always_comb begin
    dev_cap = cfg_i.target[TgtW-1:4];
    dev_sum = 52'(deviation_q) + 52'(ft) - 52'($signed({1'b0, cfg_i.target}));
    if (dev_sum > $signed(52'(dev_cap))) begin
      dev_sum = $signed(52'(dev_cap));
    end
    dev_upd = sat_s40(dev_sum);
  end

  assign late_lim = (TgtW+1)'(cfg_i.target) + (TgtW+1)'(cfg_i.target[TgtW-1:3]);
  assign late     = ft > $signed(49'(late_lim));

  always_comb begin
    late_n   = late_count_q;
    ontime_n = ontime_count_q;
    if (late) begin
      if (late_count_q != '1) begin
        late_n = late_count_q + 1'b1;
      end
    end else if (ontime_count_q != '1) begin
      ontime_n = ontime_count_q + 1'b1;
    end
    bump_hit = ((37'(late_n) * 37'd20) > 37'(ontime_n)) && (late_n > 32'd10);
    bump_sum = (CntW+1)'(threshold_bump_q) + (CntW+1)'(cfg_i.target[TgtW-1:3]);
  end

  always_comb begin
    last_frame_time_d     = last_frame_time_q;
    deviation_d           = deviation_q;
    late_count_d          = late_count_q;
    ontime_count_d        = ontime_count_q;
    threshold_bump_d      = threshold_bump_q;
    wake_pending_d        = wake_pending_q;
    pending_sleep_d       = pending_sleep_q;
    result_o.action       = ACT_STRAY;
    result_o.sleep_total  = '0;
    result_o.coarse_sleep = '0;

    if (!item_i.req_type) begin
      wake_pending_d = 1'b0;
      if (bypass) begin
        result_o.action = ACT_BYPASS;
      end else if (slow) begin
        deviation_d       = '0;
        last_frame_time_d = item_i.timestamp;
        result_o.action   = ACT_SLOW;
      end else begin
        result_o.sleep_total = sleep;
        if (sleep <= 40'sd0) begin
          deviation_d       = dev_upd;
          last_frame_time_d = item_i.timestamp;
          result_o.action   = ACT_DONE;
        end else begin
          if (coarse_diff > 41'sd0) begin
            result_o.coarse_sleep = coarse_diff[CoarseW-1:0];
          end
          wake_pending_d  = 1'b1;
          pending_sleep_d = sleep;
          result_o.action = ACT_SLEEP;
        end
      end
    end else if (wake_pending_q) begin
      late_count_d   = late_n;
      ontime_count_d = ontime_n;
      if (bump_hit) begin
        late_count_d     = '0;
        ontime_count_d   = '0;
        threshold_bump_d = bump_sum[CntW] ? {CntW{1'b1}} : bump_sum[CntW-1:0];
      end
      deviation_d          = dev_upd;
      last_frame_time_d    = item_i.timestamp;
      wake_pending_d       = 1'b0;
      result_o.sleep_total = pending_sleep_q;
      result_o.action      = ACT_DONE;
    end

    // report the threshold after this transaction's update
    result_o.threshold = sat_th(cfg_i.gran, threshold_bump_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_frame_time_q <= '0;
      deviation_q       <= '0;
      late_count_q      <= '0;
      ontime_count_q    <= '0;
      threshold_bump_q  <= '0;
      wake_pending_q    <= 1'b0;
      pending_sleep_q   <= '0;
    end else if (fire_i) begin
      last_frame_time_q <= last_frame_time_d;
      deviation_q       <= deviation_d;
      late_count_q      <= late_count_d;
      ontime_count_q    <= ontime_count_d;
      threshold_bump_q  <= threshold_bump_d;
      wake_pending_q    <= wake_pending_d;
      pending_sleep_q   <= pending_sleep_d;
    end
  end

  a_pending_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wake_pending_q |-> pending_sleep_q > 40'sd0)
    else $error("wake pending with a sleep that is not positive");

  a_sleep_arms_wake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (result_o.action == ACT_SLEEP) |=> wake_pending_q)
    else $error("requested sleep did not arm the wake");

  a_stray_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.req_type && !wake_pending_q |=>
      $stable(last_frame_time_q) && $stable(deviation_q) && $stable(threshold_bump_q))
    else $error("stray wake changed state");

  a_coarse_only_sleep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (result_o.coarse_sleep != '0) |-> result_o.action == ACT_SLEEP)
    else $error("coarse sleep outside a sleep request");

endmodule
`default_nettype wire

// ----- hw/rtl/frame_pacing_limiter.sv -----
`default_nettype none
// Frame pacer working in 100 ns ticks. Each input transaction is either a
// present event or a wake report; each yields exactly one result transaction
// carrying the action, the sleep to perform, its coarse timer part and the
// current sleep threshold. The block takes one transaction per cycle while
// the result output is not stalled: a transaction lands in the input
// register, then a single pass of combinational logic updates the pacing
// state and loads the result register, while the input register can take
// the next one. Every transaction reads and writes the pacing state in
// that single pass. Write the configuration registers only while no
// transaction is in flight.
module frame_pacing_limiter (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [fpl_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [fpl_pkg::CfgW-1:0]    cfg_wdata_i,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [71:0]                 s_axis_tdata,   // timestamp, sync_interval, pad
  input  wire logic [0:0]                  s_axis_tuser,   // req_type
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic [111:0]                     m_axis_tdata,   // sleep_total, coarse_sleep,
                                                           // threshold, pad
  output logic [2:0]                       m_axis_tuser    // action
);
  import fpl_pkg::*;

  cfg_t    cfg_q;
  item_t   in_item;
  item_t   core_item;
  result_t core_result;
  result_t out_result;
  logic    core_valid;
  logic    core_ready;
  logic    core_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target  <= '0;
      cfg_q.refresh <= '0;
      cfg_q.gran    <= GRAN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TARGET:  cfg_q.target  <= cfg_wdata_i[TgtW-1:0];
        CFG_REFRESH: cfg_q.refresh <= cfg_wdata_i[RefW-1:0];
        CFG_GRAN:    cfg_q.gran    <= cfg_wdata_i[GranW-1:0];
        default:     cfg_q         <= cfg_q;
      endcase
    end
  end

  assign in_item.req_type      = s_axis_tuser[0];
  assign in_item.timestamp     = s_axis_tdata[TsW-1:0];
  assign in_item.sync_interval = s_axis_tdata[TsW+SyncW-1:TsW];

  fpl_reg_stage #(.T(item_t)) u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_data_i  (in_item),
    .m_valid_o (core_valid),
    .m_ready_i (core_ready),
    .m_data_o  (core_item)
  );

  assign core_fire = core_valid && core_ready;

  fpl_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .fire_i   (core_fire),
    .item_i   (core_item),
    .result_o (core_result)
  );

  fpl_reg_stage #(.T(result_t)) u_out_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (core_valid),
    .s_ready_o (core_ready),
    .s_data_i  (core_result),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (out_result)
  );

  assign m_axis_tuser = out_result.action;
  assign m_axis_tdata = {1'b0, out_result.threshold, out_result.coarse_sleep,
                         out_result.sleep_total};

endmodule
`default_nettype wire
